### design/ibr_pkg.sv
// Shared types and constants for the icon bitmap to RGBA decoder.
// No dependencies.
package ibr_pkg;

	localparam logic [1:0] CMD_START   = 2'd0;
	localparam logic [1:0] CMD_PALETTE = 2'd1;
	localparam logic [1:0] CMD_MAP     = 2'd2;
	localparam logic [1:0] CMD_MASK    = 2'd3;

	localparam logic [2:0] DEPTH_1  = 3'd0;
	localparam logic [2:0] DEPTH_4  = 3'd1;
	localparam logic [2:0] DEPTH_8  = 3'd2;
	localparam logic [2:0] DEPTH_24 = 3'd3;

	localparam logic [1:0] REG_DEPTH  = 2'd0;
	localparam logic [1:0] REG_WIDTH  = 2'd1;
	localparam logic [1:0] REG_HEIGHT = 2'd2;

	// Largest icon and palette that the stores hold.
	localparam int IMG_W_LIMIT = 64;
	localparam int IMG_H_LIMIT = 64;
	localparam int PAL_ENTRIES = 256;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] data_byte;
	} item_t;

endpackage

### design/ibr_if.sv
// Handshake interfaces for the decoder: input stream, output pixels, register writes.
// Depends on nothing.
interface ibr_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] cmd;
	logic [7:0] data_byte;
	modport source (output valid, cmd, data_byte, input ready);
	modport sink (input valid, cmd, data_byte, output ready);
endinterface

interface ibr_out_if;
	logic        valid;
	logic        ready;
	logic [11:0] pixel_addr;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic [7:0]  alpha;
	logic        last;
	logic        image_done;
	modport source (output valid, pixel_addr, red, green, blue, alpha, last, image_done,
		input ready);
	modport sink (input valid, pixel_addr, red, green, blue, alpha, last, image_done,
		output ready);
endinterface

interface ibr_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] index;
	logic [6:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### design/ibr_front.sv
// Front end: accepts input transfers into a short queue.
// Depends on ibr_pkg.
module ibr_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  ibr_pkg::item_t  in_item,
	output logic            q_valid,
	input  logic            q_pop,
	output ibr_pkg::item_t  q_item
);
	ibr_pkg::item_t mem_q [4];
	logic [1:0] wr_q, rd_q;
	logic [2:0] cnt_q;
	logic push;

	assign in_ready = (cnt_q != 3'd4);
	assign push = in_valid && in_ready;
	assign q_valid = (cnt_q != 3'd0);
	assign q_item = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= in_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 2'd1;
			if (q_pop) rd_q <= rd_q + 2'd1;
			cnt_q <= cnt_q + {2'b0, push} - {2'b0, q_pop};
		end
	end
endmodule

### design/ibr_back.sv
// Back end: palette, pixel store, map unpacking and mask release.
// Depends on ibr_pkg.
module ibr_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	output logic           q_pop,
	input  ibr_pkg::item_t q_item,
	input  logic [2:0]     pixel_depth,
	input  logic [6:0]     image_width,
	input  logic [6:0]     image_height,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [11:0]    pixel_addr,
	output logic [7:0]     red,
	output logic [7:0]     green,
	output logic [7:0]     blue,
	output logic [7:0]     alpha,
	output logic           last,
	output logic           image_done
);
	localparam int STORE = ibr_pkg::IMG_W_LIMIT * ibr_pkg::IMG_H_LIMIT;
	localparam int AW = $clog2(STORE);
	localparam int WW = $clog2(ibr_pkg::IMG_W_LIMIT + 1);
	localparam int HW = $clog2(ibr_pkg::IMG_H_LIMIT + 1);
	localparam int PW = $clog2(ibr_pkg::PAL_ENTRIES);
	localparam int PPW = $clog2(ibr_pkg::PAL_ENTRIES * 4 + 1);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_MAP  = 5'b00010,
		ST_MASK = 5'b00100,
		ST_OUT  = 5'b01000,
		ST_PAL  = 5'b10000
	} state_t;

	state_t state_q;
	logic [23:0] pal_q [ibr_pkg::PAL_ENTRIES];
	logic [ibr_pkg::PAL_ENTRIES-1:0] pal_v_q;
	logic [31:0] pix_q [STORE];
	logic [PPW-1:0] pal_pos_q;
	logic [HW-1:0] map_row_q, mask_row_q;
	logic [7:0] map_rb_q;
	logic [WW-1:0] map_col_q;
	logic [23:0] part_q;
	logic [1:0] bip_q;
	logic [3:0] mask_rb_q;
	logic [7:0] byte_q;
	logic [3:0] i_q, n_q;
	logic [31:0] rd_q;
	logic [23:0] pal_rd_q;
	logic pal_hit_q;
	logic [AW-1:0] raddr_q;
	logic rlast_q, rdone_q, rset_q;

	// Effective geometry, saturated.
	logic [WW-1:0] w;
	logic [HW-1:0] h;
	logic [5:0] bits;
	always_comb begin
		if (image_width == 7'd0) w = WW'(1);
		else if ({25'd0, image_width} > ibr_pkg::IMG_W_LIMIT) w = WW'(ibr_pkg::IMG_W_LIMIT);
		else w = WW'(image_width);
		if (image_height == 7'd0) h = HW'(1);
		else if ({25'd0, image_height} > ibr_pkg::IMG_H_LIMIT) h = HW'(ibr_pkg::IMG_H_LIMIT);
		else h = HW'(image_height);
		case (pixel_depth)
			ibr_pkg::DEPTH_1:  bits = 6'd1;
			ibr_pkg::DEPTH_4:  bits = 6'd4;
			ibr_pkg::DEPTH_8:  bits = 6'd8;
			ibr_pkg::DEPTH_24: bits = 6'd24;
			default:           bits = 6'd32;
		endcase
	end

	logic [15:0] wbits;
	logic [8:0] row_bytes;
	logic [3:0] mask_rbytes;
	assign wbits = 16'(w) * 16'(bits);
	assign row_bytes = 9'(((wbits + 16'd31) >> 5) << 2);
	assign mask_rbytes = 4'(((9'(w) + 9'd31) >> 5) << 2);

	logic [3:0] npix;
	assign npix = (bits == 6'd1) ? 4'd8 : (bits == 6'd4) ? 4'd2 : 4'd1;

	// Palette index for map step i_q.
	logic [7:0] idx;
	always_comb begin
		case (bits)
			6'd1: idx = {7'd0, byte_q[3'd7 - i_q[2:0]]};
			6'd4: idx = i_q[0] ? {4'd0, byte_q[3:0]} : {4'd0, byte_q[7:4]};
			default: idx = byte_q;
		endcase
	end
	logic [23:0] pal_col;
	assign pal_col = pal_hit_q ? pal_rd_q : 24'd0;

	logic [AW+1:0] flip_map, flip_mask;
	assign flip_map = (AW+2)'((h - 1'b1 - map_row_q)) * (AW+2)'(w) + (AW+2)'(map_col_q);

	logic [10:0] mx;
	assign mx = {4'd0, mask_rb_q, 3'd0} + {7'd0, i_q};
	assign flip_mask = (AW+2)'((h - 1'b1 - mask_row_q)) * (AW+2)'(w) + (AW+2)'(mx);

	// Last released pixel of the byte: count of columns still inside w.
	logic [10:0] cnt_in;
	always_comb begin
		if ({4'd0, mask_rb_q, 3'd0} >= 11'(w)) cnt_in = 11'd0;
		else if (11'(w) - {4'd0, mask_rb_q, 3'd0} > 11'd8) cnt_in = 11'd8;
		else cnt_in = 11'(w) - {4'd0, mask_rb_q, 3'd0};
	end

	logic out_hold;
	assign out_hold = out_valid && !out_ready;
	assign q_pop = (state_q == ST_IDLE) && q_valid;

	logic [31:0] map_word;
	assign map_word = (bits <= 6'd8) ? {8'd0, pal_col}
		: {(bits == 6'd32) ? byte_q : 8'd0, (bip_q < 2'd3) ? (part_q | (24'(byte_q) << (8 * bip_q)))
			: part_q};

	always_ff @(posedge clk) begin
		if (state_q == ST_MAP && map_col_q < w && flip_map < (AW+2)'(STORE)
			&& (bits <= 6'd8 || {4'd0, bip_q} >= bits[5:3] - 1'b1))
			pix_q[flip_map[AW-1:0]] <= map_word;
		if (state_q == ST_MASK)
			rd_q <= pix_q[flip_mask[AW-1:0]];
		if (state_q == ST_PAL)
			pal_rd_q <= pal_q[idx];
		if (q_pop && q_item.cmd == ibr_pkg::CMD_PALETTE
			&& pal_pos_q < PPW'(ibr_pkg::PAL_ENTRIES * 4) && pal_pos_q[1:0] != 2'd3) begin
			// The first byte of an entry is written with the upper bytes cleared.
			case (pal_pos_q[1:0])
				2'd0: pal_q[pal_pos_q[PW+1:2]] <= {16'd0, q_item.data_byte};
				2'd1: pal_q[pal_pos_q[PW+1:2]][15:8] <= q_item.data_byte;
				default: pal_q[pal_pos_q[PW+1:2]][23:16] <= q_item.data_byte;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pal_v_q <= '0;
			pal_pos_q <= '0;
			pal_hit_q <= 1'b0;
			map_row_q <= '0; map_rb_q <= '0; map_col_q <= '0;
			part_q <= '0; bip_q <= '0; mask_row_q <= '0; mask_rb_q <= '0;
			byte_q <= '0; i_q <= '0; n_q <= '0;
			out_valid <= 1'b0; raddr_q <= '0; rlast_q <= 1'b0; rdone_q <= 1'b0;
			rset_q <= 1'b0;
			pixel_addr <= '0; red <= '0; green <= '0; blue <= '0; alpha <= '0;
			last <= 1'b0; image_done <= 1'b0;
		end else begin
			if (out_valid && out_ready && state_q != ST_OUT) out_valid <= 1'b0;
			case (state_q)
				ST_IDLE: if (q_valid) begin
					byte_q <= q_item.data_byte;
					i_q <= '0;
					case (q_item.cmd)
						ibr_pkg::CMD_START: begin
							pal_v_q <= '0; pal_pos_q <= '0;
							map_row_q <= '0; map_rb_q <= '0; map_col_q <= '0;
							part_q <= '0; bip_q <= '0; mask_row_q <= '0; mask_rb_q <= '0;
						end
						ibr_pkg::CMD_PALETTE:
							if (pal_pos_q < PPW'(ibr_pkg::PAL_ENTRIES * 4)) begin
								if (pal_pos_q[1:0] == 2'd0) pal_v_q[pal_pos_q[PW+1:2]] <= 1'b1;
								pal_pos_q <= pal_pos_q + 1'b1;
							end
						ibr_pkg::CMD_MAP:
							if (map_row_q < h) begin
								if (bits > 6'd8) state_q <= ST_MAP;
								else state_q <= ST_PAL;
							end
						default:
							if (mask_row_q < h) begin
								n_q <= cnt_in[3:0];
								state_q <= ST_MASK;
							end
					endcase
				end
				ST_PAL: begin
					pal_hit_q <= pal_v_q[idx] && ({24'd0, idx} < ibr_pkg::PAL_ENTRIES);
					state_q <= ST_MAP;
				end
				ST_MAP: begin
					if (bits > 6'd8) begin
						if ({4'd0, bip_q} >= bits[5:3] - 1'b1) begin
							if (map_col_q < w) map_col_q <= map_col_q + 1'b1;
							part_q <= '0; bip_q <= '0;
						end else begin
							part_q <= map_word[23:0];
							bip_q <= bip_q + 1'b1;
						end
					end else if (map_col_q < w) map_col_q <= map_col_q + 1'b1;
					if (bits > 6'd8 || i_q + 1'b1 >= npix) begin
						state_q <= ST_IDLE;
						if (9'(map_rb_q) + 9'd1 >= row_bytes) begin
							map_rb_q <= '0; map_col_q <= '0; part_q <= '0; bip_q <= '0;
							map_row_q <= map_row_q + 1'b1;
						end else map_rb_q <= map_rb_q + 1'b1;
					end else state_q <= ST_PAL;
					i_q <= i_q + 1'b1;
				end
				ST_MASK: begin
					if (i_q >= n_q) begin
						state_q <= ST_IDLE;
						if (mask_rb_q + 4'd1 >= mask_rbytes) begin
							mask_rb_q <= '0; mask_row_q <= mask_row_q + 1'b1;
						end else mask_rb_q <= mask_rb_q + 1'b1;
					end else begin
						raddr_q <= flip_mask[AW-1:0];
						rlast_q <= (i_q + 1'b1 == n_q);
						rdone_q <= (mask_row_q == h - 1'b1) && (mx == 11'(w) - 11'd1);
						rset_q <= byte_q[3'd7 - i_q[2:0]];
						i_q <= i_q + 1'b1;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: if (!out_hold) begin
					out_valid <= 1'b1;
					pixel_addr <= 12'(raddr_q);
					red <= rd_q[23:16]; green <= rd_q[15:8]; blue <= rd_q[7:0];
					alpha <= (bits == 6'd32) ? rd_q[31:24] : (rset_q ? 8'd0 : 8'd255);
					last <= rlast_q; image_done <= rdone_q;
					state_q <= ST_MASK;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

### design/icon_bitmap_to_rgba.sv
// Icon bitmap to RGBA decoder, top level. An input transfer is written into a four-entry queue,
// from which the back end takes one byte at a time: a start or palette byte in its idle state,
// a 24/32 bpp map byte through ST_MAP, a palette map byte through ST_PAL and ST_MAP per pixel,
// and a mask byte through ST_MASK and ST_OUT per released pixel; a stalled output holds it.
// Reset clears the palette valid flags, counters, registers and queue; the pixel store is not
// cleared.
module icon_bitmap_to_rgba (
	input logic clk,
	input logic arst_n,
	ibr_in_if.sink   in_ch,
	ibr_out_if.source out_ch,
	ibr_cfg_if.sink  cfg
);
	logic [2:0] depth_q;
	logic [6:0] width_q, height_q;
	logic q_valid, q_pop;
	ibr_pkg::item_t in_item, q_item;

	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= 3'd0; width_q <= 7'd16; height_q <= 7'd16;
		end else if (cfg.valid) begin
			case (cfg.index)
				ibr_pkg::REG_DEPTH:  depth_q <= cfg.data[2:0];
				ibr_pkg::REG_WIDTH:  width_q <= cfg.data;
				ibr_pkg::REG_HEIGHT: height_q <= cfg.data;
				default: ;
			endcase
		end
	end

	assign in_item.cmd = in_ch.cmd;
	assign in_item.data_byte = in_ch.data_byte;

	ibr_front u_front (.clk, .arst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.in_item, .q_valid, .q_pop, .q_item);

	ibr_back u_back (
		.clk, .arst_n, .q_valid, .q_pop, .q_item,
		.pixel_depth(depth_q), .image_width(width_q), .image_height(height_q),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready), .pixel_addr(out_ch.pixel_addr),
		.red(out_ch.red), .green(out_ch.green), .blue(out_ch.blue), .alpha(out_ch.alpha),
		.last(out_ch.last), .image_done(out_ch.image_done));
endmodule

### verif/tb_icon_bitmap_to_rgba.sv
// Self-checking testbench for icon_bitmap_to_rgba: builds icon images, predicts every pixel.
// Depends on ibr_pkg, the ibr_*_if interfaces and the decoder top level.
module tb_icon_bitmap_to_rgba;
	import ibr_pkg::*;

	localparam logic [2:0] DEPTH_32 = 3'd4;
	localparam int IDLE_LIMIT = 5000;
	localparam int SETTLE_CYCLES = 200;

	typedef struct {
		logic [11:0] pixel_addr;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [7:0]  alpha;
		logic        last;
		logic        image_done;
	} pixel_t;

	logic clk;
	logic arst_n;

	ibr_in_if  in_ch();
	ibr_out_if out_ch();
	ibr_cfg_if cfg();

	icon_bitmap_to_rgba dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg    (cfg)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Decoder shadow state.
	logic [2:0]  depth_code;
	logic [6:0]  width_reg;
	logic [6:0]  height_reg;
	logic [23:0] palette [256];
	logic [31:0] pixels [4096];
	bit          pixel_written [4096];
	int unsigned pal_pos, map_row, map_row_byte, map_col, partial, byte_pos;
	int unsigned mask_row, mask_row_byte;

	item_t  item_q[$];
	pixel_t pixel_q[$];
	int     errors = 0;

	function automatic int unsigned cur_w();
		if (width_reg < 1) return 1;
		if (width_reg > 64) return 64;
		return width_reg;
	endfunction

	function automatic int unsigned cur_h();
		if (height_reg < 1) return 1;
		if (height_reg > 64) return 64;
		return height_reg;
	endfunction

	function automatic int unsigned bpp();
		case (depth_code)
			DEPTH_1:  return 1;
			DEPTH_4:  return 4;
			DEPTH_8:  return 8;
			DEPTH_24: return 24;
			default:  return 32;
		endcase
	endfunction

	function automatic int unsigned map_bytes_per_row();
		return ((cur_w() * bpp() + 31) / 32) * 4;
	endfunction

	function automatic int unsigned mask_bytes_per_row();
		return ((cur_w() + 31) / 32) * 4;
	endfunction

	task automatic clear_image();
		foreach (palette[i]) palette[i] = '0;
		pal_pos = 0;
		map_row = 0;
		map_row_byte = 0;
		map_col = 0;
		partial = 0;
		byte_pos = 0;
		mask_row = 0;
		mask_row_byte = 0;
	endtask

	task automatic store_pixel(input logic [31:0] word);
		int unsigned addr;
		if (map_col < cur_w()) begin
			addr = (cur_h() - 1 - map_row) * cur_w() + map_col;
			pixels[addr] = word;
			pixel_written[addr] = 1'b1;
			map_col++;
		end
	endtask

	task automatic unpack_map_byte(input logic [7:0] b);
		int unsigned bits, n, idx, last_b;
		bits = bpp();
		if (map_row >= cur_h()) return;
		if (bits <= 8) begin
			n = 8 / bits;
			for (int i = 0; i < n; i++) begin
				idx = (b >> (8 - bits * (i + 1))) & ((1 << bits) - 1);
				store_pixel({8'h00, palette[idx]});
			end
		end else begin
			last_b = bits / 8 - 1;
			if (byte_pos < 3) partial |= b << (8 * byte_pos);
			if (byte_pos >= last_b) begin
				store_pixel({(bits == 32) ? b : 8'h00, partial[23:0]});
				partial = 0;
				byte_pos = 0;
			end else begin
				byte_pos++;
			end
		end
		map_row_byte++;
		if (map_row_byte >= map_bytes_per_row()) begin
			map_row_byte = 0;
			map_col = 0;
			partial = 0;
			byte_pos = 0;
			map_row++;
		end
	endtask

	// A mask byte may only release pixels that the map has already filled.
	function automatic bit mask_reads_written();
		int unsigned x;
		if (mask_row >= cur_h()) return 1'b1;
		for (int i = 0; i < 8; i++) begin
			x = mask_row_byte * 8 + i;
			if (x < cur_w() && !pixel_written[(cur_h() - 1 - mask_row) * cur_w() + x])
				return 1'b0;
		end
		return 1'b1;
	endfunction

	task automatic release_mask_byte(input logic [7:0] b);
		int unsigned x, addr, w, h;
		pixel_t p;
		pixel_t row_px[$];
		w = cur_w();
		h = cur_h();
		if (mask_row >= h) return;
		for (int i = 0; i < 8; i++) begin
			x = mask_row_byte * 8 + i;
			if (x < w) begin
				addr = (h - 1 - mask_row) * w + x;
				p.pixel_addr = addr[11:0];
				p.red = pixels[addr][23:16];
				p.green = pixels[addr][15:8];
				p.blue = pixels[addr][7:0];
				if (bpp() == 32) p.alpha = pixels[addr][31:24];
				else p.alpha = b[7 - i] ? 8'd0 : 8'd255;
				p.last = 1'b0;
				p.image_done = (mask_row == h - 1 && x == w - 1);
				row_px.push_back(p);
			end
		end
		if (row_px.size() > 0) row_px[row_px.size() - 1].last = 1'b1;
		foreach (row_px[i]) pixel_q.push_back(row_px[i]);
		mask_row_byte++;
		if (mask_row_byte >= mask_bytes_per_row()) begin
			mask_row_byte = 0;
			mask_row++;
		end
	endtask

	// Predict and queue one byte for the driver; a mask byte over unfilled pixels is dropped.
	task automatic send_byte(input logic [1:0] c, input logic [7:0] b);
		item_t it;
		if (c == CMD_MASK && !mask_reads_written()) return;
		case (c)
			CMD_START: clear_image();
			CMD_PALETTE: begin
				if (pal_pos < 1024) begin
					if (pal_pos % 4 < 3) palette[pal_pos / 4][8 * (pal_pos % 4) +: 8] = b;
					pal_pos++;
				end
			end
			CMD_MAP: unpack_map_byte(b);
			default: release_mask_byte(b);
		endcase
		it.cmd = c;
		it.data_byte = b;
		item_q.push_back(it);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [6:0] val);
		@(posedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		case (idx)
			REG_DEPTH:  depth_code = val[2:0];
			REG_WIDTH:  width_reg = val;
			default:    height_reg = val;
		endcase
	endtask

	task automatic set_geometry(input logic [2:0] d, input logic [6:0] w, input logic [6:0] h);
		write_reg(REG_DEPTH, {4'd0, d});
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
	endtask

	// Whole image: start, palette entries, complete pixel map, complete mask.
	task automatic send_image(input int pal_entries);
		int unsigned nmap, nmask;
		send_byte(CMD_START, 8'($urandom));
		for (int i = 0; i < pal_entries * 4; i++) send_byte(CMD_PALETTE, 8'($urandom));
		nmap = map_bytes_per_row() * cur_h();
		nmask = mask_bytes_per_row() * cur_h();
		for (int i = 0; i < nmap; i++) send_byte(CMD_MAP, 8'($urandom));
		for (int i = 0; i < nmask; i++) send_byte(CMD_MASK, 8'($urandom));
	endtask

	// Sender pauses here until every queued byte went out and every pixel came back.
	task automatic wait_idle();
		while (item_q.size() != 0 || in_ch.valid) @(posedge clk);
		while (pixel_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Driver: bursts of random length separated by random gaps.
	int burst_left = 0;
	int gap_left = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready) void'(item_q.pop_front());
			if (in_ch.valid && !in_ch.ready) begin
				// Keep the offered byte until it is taken.
			end else if (gap_left > 0) begin
				gap_left--;
				in_ch.valid <= 1'b0;
			end else if (item_q.size() > 0) begin
				in_ch.valid <= 1'b1;
				in_ch.cmd <= item_q[0].cmd;
				in_ch.data_byte <= item_q[0].data_byte;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 30);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				end
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// Receiver stall pattern changes mode every so often.
	int rx_mode = 0;
	int rx_mode_left = 0;
	int rx_run = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (rx_mode_left == 0) begin
				rx_mode = $urandom_range(0, 2);
				rx_mode_left = $urandom_range(20, 200);
			end else begin
				rx_mode_left--;
			end
			case (rx_mode)
				0: out_ch.ready <= 1'b1;
				1: out_ch.ready <= $urandom_range(0, 1);
				default: begin
					if (rx_run == 0) rx_run = $urandom_range(1, 16);
					rx_run--;
					out_ch.ready <= (rx_run % 8) > 4;
				end
			endcase
		end
	end

	function automatic void compare_field(string name, logic [11:0] e, logic [11:0] a);
		if (e !== a) begin
			$display("%0t mismatch %s: expected %h actual %h", $time, name, e, a);
			errors++;
		end
	endfunction

	// Monitor and no-progress watchdog.
	int idle_cycles = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				if (pixel_q.size() == 0) begin
					$display("%0t unexpected pixel: expected none actual addr %h",
						$time, out_ch.pixel_addr);
					errors++;
				end else begin
					compare_field("pixel_addr", pixel_q[0].pixel_addr, out_ch.pixel_addr);
					compare_field("red", pixel_q[0].red, out_ch.red);
					compare_field("green", pixel_q[0].green, out_ch.green);
					compare_field("blue", pixel_q[0].blue, out_ch.blue);
					compare_field("alpha", pixel_q[0].alpha, out_ch.alpha);
					compare_field("last", pixel_q[0].last, out_ch.last);
					compare_field("image_done", pixel_q[0].image_done, out_ch.image_done);
					void'(pixel_q.pop_front());
				end
			end
			if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready)
					|| (cfg.valid && cfg.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t watchdog: no transfer, %0d pixels pending", $time, pixel_q.size());
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	initial begin
		int unsigned d, w, h;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.cmd = CMD_START;
		in_ch.data_byte = '0;
		out_ch.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = REG_DEPTH;
		cfg.data = '0;
		depth_code = DEPTH_1;
		width_reg = 7'd16;
		height_reg = 7'd16;
		foreach (pixel_written[i]) pixel_written[i] = 1'b0;
		foreach (pixels[i]) pixels[i] = '0;
		clear_image();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Single pixel, then map and mask bytes past the last row.
		set_geometry(DEPTH_1, 7'd1, 7'd1);
		send_image(2);
		send_byte(CMD_MAP, 8'hFF);
		send_byte(CMD_MASK, 8'h00);
		send_byte(CMD_MASK, 8'hFF);
		wait_idle();

		// Widest single row at 1 bpp with all-ones and all-zero mask bytes.
		set_geometry(DEPTH_1, 7'd64, 7'd1);
		send_byte(CMD_START, 8'h00);
		for (int i = 0; i < 8; i++) send_byte(CMD_PALETTE, (i % 4 == 3) ? 8'hFF : 8'(i * 17));
		for (int i = 0; i < 8; i++) send_byte(CMD_MAP, (i < 2) ? 8'h0F : 8'($urandom));
		for (int i = 0; i < 8; i++) send_byte(CMD_MASK, (i % 2) ? 8'hFF : 8'h00);
		wait_idle();

		// Two palette entries at 8 bpp, so most indexes read black; odd width pads the row.
		set_geometry(DEPTH_8, 7'd3, 7'd1);
		send_byte(CMD_START, 8'hA5);
		for (int i = 0; i < 8; i++) send_byte(CMD_PALETTE, 8'($urandom));
		for (int i = 0; i < 4; i++) send_byte(CMD_MAP, (i == 0) ? 8'h01 : 8'($urandom));
		for (int i = 0; i < 4; i++) send_byte(CMD_MASK, 8'($urandom));
		wait_idle();

		set_geometry(DEPTH_24, 7'd2, 7'd1);
		send_image(0);
		wait_idle();

		set_geometry(DEPTH_32, 7'd1, 7'd2);
		send_image(0);
		wait_idle();

		// Unused depth code behaves as 32 bpp; out-of-range sizes saturate. Only the
		// first row is sent.
		set_geometry(3'd7, 7'd0, 7'd127);
		send_byte(CMD_START, 8'($urandom));
		for (int i = 0; i < 4; i++) send_byte(CMD_MAP, 8'($urandom));
		send_byte(CMD_MASK, 8'($urandom));
		wait_idle();

		// Random small images, each followed by up to three stray bytes.
		for (int n = 0; n < 2; n++) begin
			d = $urandom_range(0, 7);
			w = $urandom_range(1, (d >= 3) ? 1 : 8);
			h = $urandom_range(1, 2);
			set_geometry(3'(d), 7'(w), 7'(h));
			send_image($urandom_range(0, 2));
			for (int i = $urandom_range(0, 3); i > 0; i--)
				send_byte(2'($urandom_range(1, 3)), 8'($urandom));
			if ($urandom_range(0, 2) == 0) begin
				// Broken sequence: restart, then one to four map or mask bytes.
				send_byte(CMD_START, 8'($urandom));
				for (int i = $urandom_range(1, 4); i > 0; i--)
					send_byte(2'($urandom_range(2, 3)), 8'($urandom));
			end
			wait_idle();
		end

		if (errors == 0 && pixel_q.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
